### design/splpk_pkg.sv
// Shared types, constants and register codes for the stereo linked peak limiter.
// No dependencies; every other design file but splpk_queue imports this package.
`timescale 1ns / 1ps

package splpk_pkg;

  // Field widths
  localparam int SAMPLE_BITS   = 16;
  localparam int GAIN_BITS     = 17;
  localparam int CEIL_BITS     = 32;
  localparam int COEFF_BITS    = 24;
  localparam int LEN_BITS      = 10;
  localparam int QUO_BITS      = GAIN_BITS - 1;
  localparam int REG_IDX_BITS  = 2;
  localparam int REG_DATA_BITS = 24;

  // Default sizes handed to the top level
  localparam int DELAY_DEPTH_DEF = 512;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_ENABLE  = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_CEILING = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_RELEASE = 2'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_DELAY   = 2'd3;

  // Reset values and fixed-point constants
  localparam logic [GAIN_BITS-1:0]  UNITY_GAIN    = 17'h10000;
  localparam logic [CEIL_BITS-1:0]  UNITY_CEIL    = 32'h8000_0000;
  localparam logic [14:0]           SMOOTH_K      = 15'd16777;  // 0.001 in Q0.24
  localparam logic [COEFF_BITS-1:0] RELEASE_RESET = 24'd16776103;
  localparam logic [LEN_BITS-1:0]   DELAY_RESET   = 10'd153;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [GAIN_BITS-1:0]          gain_now;
  } out_item_t;

  // Beat passed from front to back: delayed pair, or raw pair when bypassed
  typedef struct packed {
    logic                          pass;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } mid_item_t;

  typedef struct packed {
    logic                  enable;
    logic [GAIN_BITS-1:0]  ceiling_gain;
    logic [COEFF_BITS-1:0] release_coeff;
    logic [LEN_BITS-1:0]   delay_length;
  } cfg_t;

endpackage

### design/splpk_queue.sv
// Small synchronous FIFO built from flops, used between front and back and
// on the result side. Depends on nothing but its parameters.
`timescale 1ns / 1ps

module splpk_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

### design/splpk_front.sv
// Front end: takes input beats, runs the circular delay store and hands the
// delayed (or bypassed) pair to the back end. Uses splpk_pkg.
`timescale 1ns / 1ps

module splpk_front
  import splpk_pkg::*;
#(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      push,
  input  in_item_t  sample_in,
  output logic      full,
  output logic      mid_wr,
  output mid_item_t mid_data,
  input  logic      mid_full
);

  localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int PW = 2 * SAMPLE_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);

  localparam logic [1:0] F_CLEAR = 2'd0;
  localparam logic [1:0] F_IDLE  = 2'd1;
  localparam logic [1:0] F_PUSH  = 2'd2;

  logic [1:0]    state;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] write_slot;
  logic [PW-1:0] mem [DELAY_DEPTH];
  logic [PW-1:0] rdata;
  logic [PW-1:0] cap;
  logic          pass;
  logic          bypass;

  logic          accept;
  logic [31:0]   len_w;
  logic [31:0]   nxt_w;
  logic [AW-1:0] rd_slot;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [PW-1:0] mem_wdata;
  logic [PW-1:0] pair;

  assign full   = (state != F_IDLE) || mid_full;
  assign accept = push && !full;

  // Active length clamped to 1..DELAY_DEPTH, read slot follows the write slot
  always_comb begin
    len_w = {{(32-LEN_BITS){1'b0}}, cfg.delay_length};
    if (len_w == 32'd0) begin
      len_w = 32'd1;
    end else if (len_w > 32'(DELAY_DEPTH)) begin
      len_w = 32'(DELAY_DEPTH);
    end
    nxt_w   = 32'(write_slot) + 32'd1;
    rd_slot = (nxt_w >= len_w) ? '0 : nxt_w[AW-1:0];
  end

  // Write port: clearing sweep after reset, else the incoming pair
  assign mem_we    = (state == F_CLEAR) || (accept && cfg.enable);
  assign mem_waddr = (state == F_CLEAR) ? clr_addr : write_slot;
  assign mem_wdata = (state == F_CLEAR) ? '0 : {sample_in.left_in, sample_in.right_in};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept && cfg.enable) begin
      rdata <= mem[rd_slot];
    end
  end

  // Sequencer and write slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_CLEAR;
      clr_addr   <= '0;
      write_slot <= '0;
    end else begin
      case (state)
        F_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= F_IDLE;
          end
        end
        F_IDLE: begin
          if (accept) begin
            state <= F_PUSH;
            if (cfg.enable) begin
              write_slot <= rd_slot;
            end
          end
        end
        F_PUSH: begin
          state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  // Captured beat; bypass when the read lands on the slot just written
  always_ff @(posedge clk) begin
    if (accept) begin
      cap    <= {sample_in.left_in, sample_in.right_in};
      pass   <= !cfg.enable;
      bypass <= (rd_slot == write_slot);
    end
  end

  assign pair          = (pass || bypass) ? cap : rdata;
  assign mid_wr        = (state == F_PUSH);
  assign mid_data.pass  = pass;
  assign mid_data.left  = pair[PW-1:SAMPLE_BITS];
  assign mid_data.right = pair[SAMPLE_BITS-1:0];

endmodule

### design/splpk_back.sv
// Back end: ceiling smoothing, iterative gain division, envelope and output
// scaling, one beat at a time. Uses splpk_pkg.
`timescale 1ns / 1ps

module splpk_back
  import splpk_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      mid_empty,
  input  mid_item_t mid_data,
  output logic      mid_rd,
  output logic      out_wr,
  output out_item_t out_data,
  input  logic      out_full
);

  localparam int SB   = SAMPLE_BITS;
  localparam int CPW  = CEIL_BITS + 15;
  localparam int RPW  = GAIN_BITS + COEFF_BITS;
  localparam int MPW  = SB + GAIN_BITS + 1;
  localparam int CNTW = $clog2(QUO_BITS);
  localparam logic [CPW-1:0]  CEIL_HALF = CPW'(32'h0080_0000);
  localparam logic [MPW-1:0]  MUL_HALF  = MPW'(32768);
  localparam logic [CNTW-1:0] CNT_LAST  = CNTW'(QUO_BITS - 1);

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_CEIL  = 4'd1;
  localparam logic [3:0] B_CSTEP = 4'd2;
  localparam logic [3:0] B_TEST  = 4'd3;
  localparam logic [3:0] B_DIV   = 4'd4;
  localparam logic [3:0] B_ENV   = 4'd5;
  localparam logic [3:0] B_REL   = 4'd6;
  localparam logic [3:0] B_SCALE = 4'd7;
  localparam logic [3:0] B_PUSH  = 4'd8;

  function automatic logic [SB-1:0] mag(input logic signed [SB-1:0] x);
    mag = x[SB-1] ? SB'(-x) : SB'(x);
  endfunction

  logic [3:0]           state;
  logic [CEIL_BITS-1:0] smoothed;
  logic [GAIN_BITS-1:0] envelope;

  logic                 pass;
  logic signed [SB-1:0] a;
  logic signed [SB-1:0] b;
  logic                 up;
  logic [CPW-1:0]       cprod;
  logic [SB-1:0]        peak;
  logic [CEIL_BITS:0]   rem;
  logic [QUO_BITS-1:0]  quo;
  logic [CNTW-1:0]      cnt;
  logic                 limit;
  logic [RPW-1:0]       rprod;
  logic [MPW-1:0]       prod_a;
  logic [MPW-1:0]       prod_b;

  logic [GAIN_BITS-1:0] cg;
  logic [CEIL_BITS-1:0] tgt;
  logic [CEIL_BITS-1:0] diff;
  logic [CPW-1:0]       cround;
  logic [CEIL_BITS-1:0] step;
  logic [CEIL_BITS-1:0] den;
  logic [CEIL_BITS:0]   rem2;
  logic                 ge;
  logic [GAIN_BITS-1:0] target;
  logic [GAIN_BITS-1:0] envc;
  logic [GAIN_BITS-1:0] deficit;
  logic [SB-1:0]        sa;
  logic [SB-1:0]        sb;

  // Ceiling target and step toward it
  always_comb begin
    cg     = (cfg.ceiling_gain > UNITY_GAIN) ? UNITY_GAIN : cfg.ceiling_gain;
    tgt    = {cg, 15'b0};
    diff   = (tgt >= smoothed) ? tgt - smoothed : smoothed - tgt;
    cround = cprod + CEIL_HALF;
    step   = CEIL_BITS'(cround[CPW-1:24]);
  end

  // Restoring divider: peak scaled to Q1.31 against the smoothed ceiling
  always_comb begin
    den  = {peak, {(CEIL_BITS-SB){1'b0}}};
    rem2 = {rem[CEIL_BITS-1:0], 1'b0};
    ge   = (rem2 >= {1'b0, den});
  end

  // Envelope inputs
  always_comb begin
    target  = limit ? {1'b0, quo} : UNITY_GAIN;
    envc    = (envelope > UNITY_GAIN) ? UNITY_GAIN : envelope;
    deficit = UNITY_GAIN - envc;
  end

  // Sequencer and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      smoothed <= UNITY_CEIL;
      envelope <= UNITY_GAIN;
    end else begin
      case (state)
        B_IDLE: begin
          if (!mid_empty && !out_full) begin
            state <= mid_data.pass ? B_PUSH : B_CEIL;
          end
        end
        B_CEIL: begin
          state <= B_CSTEP;
        end
        B_CSTEP: begin
          smoothed <= up ? smoothed + step : smoothed - step;
          state    <= B_TEST;
        end
        B_TEST: begin
          state <= (den > smoothed) ? B_DIV : B_ENV;
        end
        B_DIV: begin
          if (cnt == CNT_LAST) begin
            state <= B_ENV;
          end
        end
        B_ENV: begin
          if (target < envc) begin
            envelope <= target;
            state    <= B_SCALE;
          end else begin
            state <= B_REL;
          end
        end
        B_REL: begin
          envelope <= UNITY_GAIN - GAIN_BITS'(rprod[RPW-1:24]);
          state    <= B_SCALE;
        end
        B_SCALE: begin
          state <= B_PUSH;
        end
        B_PUSH: begin
          state <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        pass <= mid_data.pass;
        a    <= mid_data.left;
        b    <= mid_data.right;
      end
      B_CEIL: begin
        up    <= (tgt >= smoothed);
        cprod <= {15'b0, diff} * {{(CPW-15){1'b0}}, SMOOTH_K};
        peak  <= (mag(a) > mag(b)) ? mag(a) : mag(b);
      end
      B_TEST: begin
        limit <= (den > smoothed);
        rem   <= {1'b0, smoothed};
        quo   <= '0;
        cnt   <= '0;
      end
      B_DIV: begin
        rem <= ge ? rem2 - {1'b0, den} : rem2;
        quo <= {quo[QUO_BITS-2:0], ge};
        cnt <= cnt + 1'b1;
      end
      B_ENV: begin
        rprod <= {{COEFF_BITS{1'b0}}, deficit} * {{GAIN_BITS{1'b0}}, cfg.release_coeff};
      end
      B_SCALE: begin
        prod_a <= {{(MPW-SB){1'b0}}, mag(a)} * {{(MPW-GAIN_BITS){1'b0}}, envelope} + MUL_HALF;
        prod_b <= {{(MPW-SB){1'b0}}, mag(b)} * {{(MPW-GAIN_BITS){1'b0}}, envelope} + MUL_HALF;
      end
      default: begin
      end
    endcase
  end

  // Rounded magnitudes with the sign put back
  assign sa = prod_a[SB+15:16];
  assign sb = prod_b[SB+15:16];

  assign mid_rd = (state == B_IDLE) && !mid_empty && !out_full;
  assign out_wr = (state == B_PUSH);

  always_comb begin
    if (pass) begin
      out_data.left_out  = a;
      out_data.right_out = b;
      out_data.gain_now  = UNITY_GAIN;
    end else begin
      out_data.left_out  = a[SB-1] ? -sa : sa;
      out_data.right_out = b[SB-1] ? -sb : sb;
      out_data.gain_now  = envelope;
    end
  end

endmodule

### design/stereo_linked_peak_limiter.sv
// Top level of the stereo linked lookahead peak limiter: configuration
// registers, front end, hand-off queue, back end and result queue. Uses splpk_pkg.
`timescale 1ns / 1ps

// A limiter item takes a stereo Q1.15 pair and returns it delayed by the
// programmed lookahead length, scaled by an envelope gain that never lets the
// delayed peak exceed the smoothed ceiling. The front end takes a new beat only
// in its idle state, after handing the last one on, and holds off while the
// hand-off queue is full. The back end works on one beat at a time; an enabled
// beat runs through its 16-step restoring divider and the multiplies around it.
// The divider is skipped when the peak stays under the ceiling, and the envelope
// either drops to the target or releases. A disabled (pass-through) beat skips
// all of that. A short queue lets the front run ahead of the back, and a
// result queue holds finished beats while the consumer stalls. After reset the
// delay store is swept to zero, one entry per cycle, with full held high until
// the sweep ends; configuration writes are taken during that sweep. Write
// configuration only while no beat is in flight.
module stereo_linked_peak_limiter
  import splpk_pkg::*;
#(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  in_item_t                 sample_in,
  output logic                     empty,
  input  logic                     pop,
  output out_item_t                result,
  input  logic                     wr_en,
  input  logic [REG_IDX_BITS-1:0]  wr_index,
  input  logic [REG_DATA_BITS-1:0] wr_data
);

  cfg_t      cfg;
  logic      mid_wr;
  mid_item_t mid_wdata;
  mid_item_t mid_rdata;
  logic      mid_rd;
  logic      mid_full;
  logic      mid_empty;
  logic      out_wr;
  out_item_t out_wdata;
  logic      out_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= 1'b0;
      cfg.ceiling_gain  <= UNITY_GAIN;
      cfg.release_coeff <= RELEASE_RESET;
      cfg.delay_length  <= DELAY_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_ENABLE:  cfg.enable        <= wr_data[0];
        REG_CEILING: cfg.ceiling_gain  <= wr_data[GAIN_BITS-1:0];
        REG_RELEASE: cfg.release_coeff <= wr_data[COEFF_BITS-1:0];
        REG_DELAY:   cfg.delay_length  <= wr_data[LEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  splpk_front #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .sample_in(sample_in),
    .full     (full),
    .mid_wr   (mid_wr),
    .mid_data (mid_wdata),
    .mid_full (mid_full)
  );

  splpk_queue #(
    .WIDTH($bits(mid_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (mid_wr),
    .wdata(mid_wdata),
    .rd   (mid_rd),
    .rdata(mid_rdata),
    .full (mid_full),
    .empty(mid_empty)
  );

  splpk_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .mid_empty(mid_empty),
    .mid_data (mid_rdata),
    .mid_rd   (mid_rd),
    .out_wr   (out_wr),
    .out_data (out_wdata),
    .out_full (out_full)
  );

  splpk_queue #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (out_wr),
    .wdata(out_wdata),
    .rd   (pop),
    .rdata(result),
    .full (out_full),
    .empty(empty)
  );

endmodule

### design/splpk_checker.sv
// Port-level checks for the peak limiter, attached to the top level by bind.
// Uses splpk_pkg and the top level's ports only.
`timescale 1ns / 1ps

module splpk_checker
  import splpk_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  // Reset starts the delay store sweep, which blocks input
  a_full_after_reset: assert property (@(posedge clk) rst |=> full)
    else $error("input not blocked after reset");

  // Reset leaves no result waiting
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // Applied gain never exceeds unity
  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.gain_now <= UNITY_GAIN))
    else $error("gain above unity");

  // A waiting result is neither dropped nor changed until taken
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result lost or changed");

endmodule

bind stereo_linked_peak_limiter splpk_checker u_splpk_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .result(result)
);
